// ===== rtl/uicf_pkg.sv =====
`default_nettype none

package uicf_pkg;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_S = 8'h53;

   localparam logic KIND_FORWARD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_CONT  = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HEAD_A  = 3'd1,
      PH_PASS    = 3'd2,
      PH_SCAN    = 3'd3,
      PH_SCAN_A  = 3'd4,
      PH_SCAN_AT = 3'd5,
      PH_COUNT   = 3'd6,
      PH_FRAME   = 3'd7
   } phase_type;

   typedef struct packed {
      logic       run_last;
      logic       event_kind;
      logic [7:0] out_byte;
      logic [1:0] send_mode;
      logic [7:0] chunk_pos;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic result_type status_item();
      result_type r;
      r.run_last   = 1'b0;
      r.event_kind = KIND_STATUS;
      r.out_byte   = 8'd0;
      r.send_mode  = MODE_PASS;
      r.chunk_pos  = 8'd0;
      return r;
   endfunction

   function automatic result_type forward_item(logic [7:0] b, logic [1:0] mode,
                                               logic [7:0] pos);
      result_type r;
      r.run_last   = 1'b0;
      r.event_kind = KIND_FORWARD;
      r.out_byte   = b;
      r.send_mode  = mode;
      r.chunk_pos  = pos;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/uart_to_i2c_command_framer.sv =====
// Turns received UART bytes, grouped into chunks by req_tlast, into I2C send
// events: forwarded bytes with their mode and chunk position, and status
// requests. A request is taken in every cycle while the four-entry result
// queue has room for two results; each request yields zero, one or two
// results, and the queue drains one result per cycle while rsp_tready is high,
// so the sustained rate is one request per cycle when requests yield at most
// one result on average. Each result is registered in the queue before output.
`default_nettype none

module uart_to_i2c_command_framer #(
   parameter int CHUNK_MAX = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // out_byte, send_mode, chunk_pos, zero fill
   output logic             rsp_tlast,
   output logic             rsp_tuser    // event_kind
);
   import uicf_pkg::*;

   push_type   push;
   result_type head;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   uicf_parser #(
      .CHUNK_MAX(CHUNK_MAX)
   ) parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_tdata),
      .chunk_end(req_tlast),
      .push     (push)
   );

   uicf_result_queue queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_item (head)
   );

   assign rsp_tdata = {6'd0, head.chunk_pos, head.send_mode, head.out_byte};
   assign rsp_tlast = head.run_last;
   assign rsp_tuser = head.event_kind;

endmodule

`default_nettype wire

// ===== rtl/uicf_parser.sv =====
`default_nettype none

module uicf_parser #(
   parameter int CHUNK_MAX = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             chunk_end,
   output uicf_pkg::push_type    push
);
   import uicf_pkg::*;

   localparam logic [7:0] POS_LIMIT = (CHUNK_MAX - 1 > 255) ? 8'd255 : 8'(CHUNK_MAX - 1);

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] position_ff, position_in;
   logic       first_ff, first_in;
   logic       pending_ff, pending_in;

   result_type list [3];
   logic [1:0] n;
   logic [7:0] rem_dec;

   always_comb begin
      list[0] = status_item();
      list[1] = status_item();
      list[2] = status_item();
      n = 2'd0;
      phase_in = phase_ff;
      remaining_in = remaining_ff;
      held_in = held_ff;
      first_in = first_ff;
      rem_dec = (remaining_ff == 8'd0) ? 8'd0 : remaining_ff - 8'd1;

      if (pending_ff) begin
         list[n] = status_item();
         n = n + 2'd1;
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == CHAR_A && !chunk_end) begin
               held_in = rx_byte;
               phase_in = PH_HEAD_A;
            end else begin
               list[n] = forward_item(rx_byte, MODE_PASS, position_ff);
               n = n + 2'd1;
               if (chunk_end) begin
                  list[n] = status_item();
                  n = n + 2'd1;
               end
               phase_in = PH_PASS;
            end
         end
         PH_HEAD_A: begin
            if (rx_byte == CHAR_T) begin
               phase_in = PH_SCAN_AT;
            end else begin
               list[n] = forward_item(held_ff, MODE_PASS, 8'd0);
               n = n + 2'd1;
               list[n] = forward_item(rx_byte, MODE_PASS, position_ff);
               n = n + 2'd1;
               if (chunk_end) begin
                  list[n] = status_item();
                  n = n + 2'd1;
               end
               phase_in = PH_PASS;
            end
         end
         PH_PASS: begin
            list[n] = forward_item(rx_byte, MODE_PASS, position_ff);
            n = n + 2'd1;
            if (chunk_end) begin
               list[n] = status_item();
               n = n + 2'd1;
            end
         end
         PH_SCAN: begin
            phase_in = (rx_byte == CHAR_A) ? PH_SCAN_A : PH_SCAN;
         end
         PH_SCAN_A: begin
            if (rx_byte == CHAR_T) begin
               phase_in = PH_SCAN_AT;
            end else begin
               phase_in = (rx_byte == CHAR_A) ? PH_SCAN_A : PH_SCAN;
            end
         end
         PH_SCAN_AT: begin
            if (rx_byte == CHAR_C) begin
               list[n] = status_item();
               n = n + 2'd1;
               phase_in = PH_SCAN;
            end else if (rx_byte == CHAR_S) begin
               phase_in = PH_COUNT;
            end else begin
               phase_in = (rx_byte == CHAR_A) ? PH_SCAN_A : PH_SCAN;
            end
         end
         PH_COUNT: begin
            remaining_in = rx_byte;
            if (rx_byte == 8'd0) begin
               phase_in = PH_SCAN;
            end else begin
               first_in = 1'b1;
               phase_in = PH_FRAME;
            end
         end
         PH_FRAME: begin
            list[n] = forward_item(rx_byte, first_ff ? MODE_START : MODE_CONT,
                                   position_ff);
            n = n + 2'd1;
            first_in = 1'b0;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               phase_in = PH_SCAN;
            end
         end
      endcase

      if (chunk_end) begin
         if (phase_in != PH_FRAME) begin
            phase_in = PH_IDLE;
         end
         position_in = 8'd0;
      end else if (position_ff < POS_LIMIT) begin
         position_in = position_ff + 8'd1;
      end else begin
         position_in = position_ff;
      end

      pending_in = (n == 2'd3);
      push.first = list[0];
      push.second = list[1];
      push.count = (n == 2'd3) ? 2'd2 : n;
      if (push.count == 2'd2) begin
         push.second.run_last = 1'b1;
      end else begin
         push.first.run_last = 1'b1;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= 8'd0;
         held_ff      <= 8'd0;
         position_ff  <= 8'd0;
         first_ff     <= 1'b0;
         pending_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         held_ff      <= held_in;
         position_ff  <= position_in;
         first_ff     <= first_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/uicf_result_queue.sv =====
`default_nettype none

module uicf_result_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire uicf_pkg::push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output uicf_pkg::result_type   out_item
);
   import uicf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign room      = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/uicf_checker.sv =====
`default_nettype none

module uicf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);
   import uicf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tdata == 24'd0)
      else $error("status request carries data");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:8] != 2'b11 && rsp_tdata[23:18] == 6'd0)
      else $error("illegal send mode or fill bits");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while no result is queued");

endmodule

bind uart_to_i2c_command_framer uicf_checker checker_inst (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
